>>> src/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants of the set-associative transposition table.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam logic [7:0] MOVE_LIMIT = 8'd80;
	localparam logic [7:0] MOVE_NONE  = 8'd255;

	localparam logic MODE_PROBE = 1'b0;
	localparam logic MODE_STORE = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [7:0]  bucket_key;
		logic [31:0] tag;
		logic [63:0] pos_id;
		logic [7:0]  depth;
		logic [7:0]  gen;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic [3:0]  flags;
		logic [7:0]  move_x;
		logic [7:0]  move_o;
	} sat_in_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  collisions;
		logic        stored;
		logic [7:0]  out_depth;
		logic [7:0]  out_gen;
		logic signed [31:0] out_lo;
		logic signed [31:0] out_hi;
		logic [3:0]  out_flags;
		logic [7:0]  out_move_x;
		logic [7:0]  out_move_o;
	} sat_out_t;

	// one way entry as held in memory: tag, depth, gen, lo, hi, flags, moves, identity
	typedef struct packed {
		logic [31:0] tag;
		logic [7:0]  depth;
		logic [7:0]  gen;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic [3:0]  flags;
		logic [7:0]  mx;
		logic [7:0]  mo;
		logic [63:0] ident;
	} sat_way_t;

	function automatic logic [7:0] norm_move(input logic [7:0] m);
		return (m > MOVE_LIMIT) ? MOVE_NONE : m;
	endfunction

endpackage

>>> src/sat_ram.sv
// ----------------------------------------------------------------------------
// sat_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/set_assoc_transposition_table_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_transposition_table_unit
// Set-associative table of search results: probe and store over one bucket.
// ----------------------------------------------------------------------------
//  channel   signals                        direction
//  in        in_valid, in_stall, in_data    beat in
//  out       out_valid, out_stall, out_data beat out
//  cfg       cfg_we, cfg_wdata              register write
//
//  a beat is taken in idle, then the ways are read one per cycle through
//  a single memory port and one shared compare unit, a decide state follows and the
//  result is offered next; a store writes its way back while the result is offered,
//  and the next beat is taken only after the result has left.
//  after reset a clearing pass of one cycle per slot clears the valid memory;
//  in_stall is high meanwhile and while a beat is in work or a result waits.
// ----------------------------------------------------------------------------
module set_assoc_transposition_table_unit #(
	parameter int SLOT_BITS = 10,
	parameter int WAYS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  sat_pkg::sat_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output sat_pkg::sat_out_t out_data
);
	import sat_pkg::*;

	localparam int WL     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NB_RAW = (1 << SLOT_BITS) / WAYS;
	localparam int NB     = (NB_RAW > 0) ? NB_RAW : 1;
	localparam int BL     = (NB > 1) ? $clog2(NB) : 1;
	localparam int SLOTS  = NB * WAYS;
	localparam int AL     = $clog2(SLOTS);
	localparam int EW     = $bits(sat_way_t);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_DEC  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]  state_q;
	logic        fkm_q;
	sat_in_t     req_q;
	logic [BL-1:0] bucket_q;
	logic [AL:0] clr_q;
	logic [WL:0] rd_q;    // way being addressed
	logic [WL:0] cmp_q;   // way whose data is on the read port
	logic        cmp_v_q;
	logic        done_q;
	logic        found_q, empty_v_q;
	logic [WL-1:0] found_w_q, empty_w_q, vic_w_q;
	sat_way_t    found_e_q, vic_e_q;
	logic        vic_v_q;
	logic [2:0]  coll_q;
	sat_out_t    res_q;
	logic        wr_q;
	logic [AL-1:0] waddr_q;
	sat_way_t    wdata_q;

	// memories
	logic [AL-1:0] raddr;
	logic          ram_we;
	logic [AL-1:0] ram_waddr;
	sat_way_t      rd_e;
	logic [EW-1:0] rd_raw;
	logic          v_we, v_wd, v_rd;

	function automatic logic [AL-1:0] slot_addr(input logic [BL-1:0] b, input logic [WL-1:0] w);
		logic [AL+BL+WL:0] a;
		a = (AL+BL+WL+1)'(b) * (AL+BL+WL+1)'(WAYS) + (AL+BL+WL+1)'(w);
		return a[AL-1:0];
	endfunction

	assign raddr = slot_addr(bucket_q, rd_q[WL-1:0]);

	sat_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ent (
		.clk(clk), .we(wr_q), .waddr(waddr_q), .wdata(wdata_q),
		.raddr(raddr), .rdata(rd_raw)
	);
	assign rd_e = sat_way_t'(rd_raw);

	assign v_we      = (state_q == ST_CLR) || wr_q;
	assign ram_waddr = (state_q == ST_CLR) ? clr_q[AL-1:0] : waddr_q;
	assign v_wd      = (state_q != ST_CLR);
	assign ram_we    = v_we;

	sat_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_vld (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(v_wd),
		.raddr(raddr), .rdata(v_rd)
	);

	// shared compare unit: one way per cycle
	logic        c_tag, c_id, c_match, c_stale_n, c_stale_c, c_better;
	logic signed [32:0] w_new, w_cur;
	always_comb begin
		c_tag     = (rd_e.tag == req_q.tag);
		c_id      = !fkm_q || (rd_e.ident == req_q.pos_id);
		c_match   = v_rd && c_tag && c_id;
		c_stale_n = (rd_e.gen != req_q.gen);
		c_stale_c = (vic_e_q.gen != req_q.gen);
		w_new     = 33'(rd_e.hi) - 33'(rd_e.lo);
		w_cur     = 33'(vic_e_q.hi) - 33'(vic_e_q.lo);
		if (c_stale_n != c_stale_c) begin
			c_better = c_stale_n;
		end else if (rd_e.depth != vic_e_q.depth) begin
			c_better = rd_e.depth < vic_e_q.depth;
		end else begin
			c_better = w_new > w_cur;
		end
	end

	// decision for the store
	sat_way_t    ins_e, mrg_e, new_e;
	logic signed [31:0] m_lo, m_hi;
	logic signed [32:0] w_in, w_old;
	logic [1:0]  q_new;
	logic        reject;
	always_comb begin
		ins_e.tag   = req_q.tag;
		ins_e.depth = req_q.depth;
		ins_e.gen   = req_q.gen;
		ins_e.lo    = req_q.lo;
		ins_e.hi    = req_q.hi;
		ins_e.flags = req_q.flags;
		ins_e.mx    = norm_move(req_q.move_x);
		ins_e.mo    = norm_move(req_q.move_o);
		ins_e.ident = req_q.pos_id;
		m_lo = (found_e_q.lo > req_q.lo) ? found_e_q.lo : req_q.lo;
		m_hi = (found_e_q.hi < req_q.hi) ? found_e_q.hi : req_q.hi;
		if (m_lo > m_hi) begin
			m_lo = found_e_q.lo;
			m_hi = found_e_q.hi;
		end
		q_new = (found_e_q.flags[1:0] > req_q.flags[1:0]) ? found_e_q.flags[1:0]
			: req_q.flags[1:0];
		mrg_e       = ins_e;
		mrg_e.depth = found_e_q.depth;
		mrg_e.lo    = m_lo;
		mrg_e.hi    = m_hi;
		mrg_e.flags = {found_e_q.flags[3] | req_q.flags[3],
			found_e_q.flags[2] & req_q.flags[2], q_new};
		mrg_e.mx    = (found_e_q.mx > MOVE_LIMIT) ? ins_e.mx : found_e_q.mx;
		mrg_e.mo    = (found_e_q.mo > MOVE_LIMIT) ? ins_e.mo : found_e_q.mo;
		w_in   = 33'(req_q.hi) - 33'(req_q.lo);
		w_old  = 33'(found_e_q.hi) - 33'(found_e_q.lo);
		reject = found_q && (req_q.depth < found_e_q.depth) && (w_in > w_old);
		new_e  = (found_q && req_q.depth == found_e_q.depth) ? mrg_e : ins_e;
	end

	// result of the beat
	sat_out_t res_d;
	always_comb begin
		res_d            = '0;
		res_d.collisions = coll_q;
		if (req_q.mode == MODE_PROBE) begin
			if (found_q) begin
				res_d.hit        = 1'b1;
				res_d.out_depth  = found_e_q.depth;
				res_d.out_gen    = found_e_q.gen;
				res_d.out_lo     = found_e_q.lo;
				res_d.out_hi     = found_e_q.hi;
				res_d.out_flags  = found_e_q.flags;
				res_d.out_move_x = found_e_q.mx;
				res_d.out_move_o = found_e_q.mo;
			end
		end else begin
			res_d.stored = !reject;
		end
	end

	// bucket of every key value
	logic [BL-1:0] bkt_lut [256];
	for (genvar k = 0; k < 256; k++) begin : g_bkt
		assign bkt_lut[k] = BL'(k % NB);
	end

	logic [BL-1:0] in_bucket;
	assign in_bucket = bkt_lut[in_data.bucket_key];

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			fkm_q   <= 1'b0;
			wr_q    <= 1'b0;
			cmp_v_q <= 1'b0;
		end else begin
			wr_q <= (state_q == ST_DEC) && (req_q.mode == MODE_STORE) && !reject;
			if (cfg_we) begin
				fkm_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AL+1)'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						req_q     <= in_data;
						bucket_q  <= in_bucket;
						rd_q      <= '0;
						cmp_v_q   <= 1'b0;
						done_q    <= 1'b0;
						found_q   <= 1'b0;
						empty_v_q <= 1'b0;
						vic_v_q   <= 1'b0;
						coll_q    <= '0;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					cmp_q   <= rd_q;
					cmp_v_q <= (rd_q < (WL+1)'(WAYS));
					if (rd_q < (WL+1)'(WAYS)) begin
						rd_q <= rd_q + 1'b1;
					end
					if (cmp_v_q && !done_q) begin
						if (!v_rd) begin
							if (!empty_v_q) begin
								empty_v_q <= 1'b1;
								empty_w_q <= cmp_q[WL-1:0];
							end
						end else if (c_tag && !c_id) begin
							coll_q <= coll_q + 1'b1;
						end else if (c_match) begin
							found_q   <= 1'b1;
							found_w_q <= cmp_q[WL-1:0];
							found_e_q <= rd_e;
							done_q    <= 1'b1;
						end
						if (!vic_v_q || (v_rd && c_better)) begin
							vic_v_q <= 1'b1;
							vic_w_q <= cmp_q[WL-1:0];
							vic_e_q <= rd_e;
						end
					end
					if (cmp_v_q && cmp_q == (WL+1)'(WAYS - 1)) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					res_q <= res_d;
					if (req_q.mode == MODE_STORE && !reject) begin
						wdata_q <= new_e;
						waddr_q <= slot_addr(bucket_q, found_q ? found_w_q
							: (empty_v_q ? empty_w_q : vic_w_q));
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> test/tb_set_assoc_transposition_table_unit.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_transposition_table_unit
// Self-checking bench for the transposition table: directed probes and stores
// from a table, then random traffic on a few buckets and later on more, checked
// beat by beat against a behavioral model of the four ways, under random idling.
// ----------------------------------------------------------------------------
module tb_set_assoc_transposition_table_unit;
	import sat_pkg::*;

	localparam int SLOT_BITS = 10;
	localparam int WAYS = 4;
	localparam int NBUCKETS = ((1 << SLOT_BITS) / WAYS) ? ((1 << SLOT_BITS) / WAYS) : 1;
	localparam int NSLOTS = NBUCKETS * WAYS;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 4 * (WAYS + 3) + 4;
	localparam int NDIR = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sat_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sat_out_t out_data;

	set_assoc_transposition_table_unit #(
		.SLOT_BITS(SLOT_BITS),
		.WAYS(WAYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// table model
	logic     tbl_valid [NSLOTS];
	sat_way_t tbl_way [NSLOTS];
	logic     key_mode;

	sat_out_t result_q [$];
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int probe_hits = 0;
	int store_writes = 0;
	int colls_seen = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_recv = 1'b0;

	function automatic logic [7:0] move_or_none(logic [7:0] m);
		return (m > MOVE_LIMIT) ? MOVE_NONE : m;
	endfunction

	function automatic logic signed [32:0] span(sat_way_t w);
		return {w.hi[31], w.hi} - {w.lo[31], w.lo};
	endfunction

	function automatic sat_way_t make_way(sat_in_t b, logic [7:0] d, logic signed [31:0] lo,
			logic signed [31:0] hi, logic [3:0] f, logic [7:0] mx, logic [7:0] mo);
		sat_way_t w;
		w.tag = b.tag;
		w.depth = d;
		w.gen = b.gen;
		w.lo = lo;
		w.hi = hi;
		w.flags = f;
		w.mx = move_or_none(mx);
		w.mo = move_or_none(mo);
		w.ident = b.pos_id;
		return w;
	endfunction

	function automatic sat_out_t table_access(sat_in_t b);
		sat_out_t r;
		int base, found, empty, v, s;
		logic [2:0] coll;
		sat_way_t o;
		logic signed [31:0] nlo, nhi;
		logic [1:0] q;
		logic [3:0] nf;
		logic [7:0] rmx, rmo;
		bit cs, us, better;
		r = '0;
		base = (b.bucket_key % NBUCKETS) * WAYS;
		found = -1;
		empty = -1;
		coll = '0;
		for (int w = 0; w < WAYS; w++) begin
			s = base + w;
			if (!tbl_valid[s]) begin
				if (empty < 0) empty = w;
			end else if (tbl_way[s].tag == b.tag) begin
				if (key_mode && tbl_way[s].ident != b.pos_id) coll++;
				else begin
					found = w;
					break;
				end
			end
		end
		r.collisions = coll;
		if (b.mode == MODE_PROBE) begin
			if (found >= 0) begin
				o = tbl_way[base + found];
				r.hit = 1'b1;
				r.out_depth = o.depth;
				r.out_gen = o.gen;
				r.out_lo = o.lo;
				r.out_hi = o.hi;
				r.out_flags = o.flags;
				r.out_move_x = o.mx;
				r.out_move_o = o.mo;
			end
			return r;
		end
		if (found >= 0) begin
			s = base + found;
			o = tbl_way[s];
			if (b.depth < o.depth && $signed({b.hi[31], b.hi} - {b.lo[31], b.lo}) > span(o))
				return r;
			if (b.depth == o.depth) begin
				nlo = (o.lo > b.lo) ? o.lo : b.lo;
				nhi = (o.hi < b.hi) ? o.hi : b.hi;
				if (nlo > nhi) begin
					nlo = o.lo;
					nhi = o.hi;
				end
				q = (o.flags[1:0] > b.flags[1:0]) ? o.flags[1:0] : b.flags[1:0];
				nf = {o.flags[3] | b.flags[3], o.flags[2] & b.flags[2], q};
				rmx = (o.mx > MOVE_LIMIT) ? b.move_x : o.mx;
				rmo = (o.mo > MOVE_LIMIT) ? b.move_o : o.mo;
				tbl_way[s] = make_way(b, o.depth, nlo, nhi, nf, rmx, rmo);
			end else begin
				tbl_way[s] = make_way(b, b.depth, b.lo, b.hi, b.flags, b.move_x, b.move_o);
			end
		end else begin
			if (empty >= 0) s = base + empty;
			else begin
				v = 0;
				for (int w = 1; w < WAYS; w++) begin
					cs = tbl_way[base + w].gen != b.gen;
					us = tbl_way[base + v].gen != b.gen;
					if (cs != us) better = cs;
					else if (tbl_way[base + w].depth != tbl_way[base + v].depth)
						better = tbl_way[base + w].depth < tbl_way[base + v].depth;
					else better = span(tbl_way[base + w]) > span(tbl_way[base + v]);
					if (better) v = w;
				end
				s = base + v;
			end
			tbl_way[s] = make_way(b, b.depth, b.lo, b.hi, b.flags, b.move_x, b.move_o);
			tbl_valid[s] = 1'b1;
		end
		r.stored = 1'b1;
		return r;
	endfunction

	// model lookup without updating the table
	function automatic sat_out_t table_peek(sat_in_t b);
		logic     sv_valid [NSLOTS];
		sat_way_t sv_way [NSLOTS];
		sat_out_t r;
		sv_valid = tbl_valid;
		sv_way = tbl_way;
		r = table_access(b);
		tbl_valid = sv_valid;
		tbl_way = sv_way;
		return r;
	endfunction

	// receiver side: stall pattern and checking
	always @(posedge clk) begin
		if (hold_recv) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (result_q.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, out_data);
				errors++;
			end else begin
				if (out_data !== result_q[0]) begin
					$display("%0t: mismatch expected %h actual %h", $time, result_q[0], out_data);
					errors++;
				end
				void'(result_q.pop_front());
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// valid stays high after the accepting edge until the next beat or an idle cycle
	task automatic send_beat(sat_in_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		result_q.push_back(table_access(b));
		if (b.mode == MODE_STORE) store_writes++;
		beats_in++;
	endtask

	task automatic set_key_mode(logic m);
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_mode = m;
	endtask

	function automatic sat_in_t beat_of(logic mode, logic [7:0] key, logic [31:0] tag,
			logic [63:0] id, logic [7:0] d, logic [7:0] g, logic signed [31:0] lo,
			logic signed [31:0] hi, logic [3:0] f, logic [7:0] mx, logic [7:0] mo);
		sat_in_t b;
		b = '{mode, key, tag, id, d, g, lo, hi, f, mx, mo};
		return b;
	endfunction

	function automatic sat_in_t random_beat(int nkeys, int ntags);
		sat_in_t b;
		b.mode = 1'($urandom_range(1));
		b.bucket_key = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(nkeys - 1));
		b.tag = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(ntags - 1));
		b.tag[31] = 1'($urandom_range(1)) & (b.tag > 3);
		b.pos_id = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(1));
		b.depth = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
		b.gen = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1));
		b.lo = ($urandom_range(3) == 0) ? $signed($urandom) : 32'sd0 - $urandom_range(70000);
		b.hi = ($urandom_range(3) == 0) ? $signed($urandom) : 32'sd0 + $urandom_range(70000);
		b.flags = 4'($urandom);
		b.move_x = ($urandom_range(1)) ? 8'($urandom) : 8'($urandom_range(80));
		b.move_o = ($urandom_range(1)) ? 8'($urandom) : 8'($urandom_range(80));
		return b;
	endfunction

	sat_in_t  dir_beat [NDIR];
	sat_out_t dir_result [NDIR];
	bit       dir_typed [NDIR];

	initial begin
		sat_out_t miss, st;
		sat_in_t b;
		for (int i = 0; i < NSLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_way[i] = '0;
		end
		key_mode = 1'b0;
		miss = '0;
		st = '0;
		st.stored = 1'b1;
		// probe of an empty table, stores with extreme fields, merges and rejects
		dir_beat[0] = beat_of(MODE_PROBE, 8'hff, 32'hffff_ffff, '1, 8'hff, 8'hff,
			32'sh7fff_ffff, 32'sh8000_0000, 4'hf, 8'hff, 8'hff);
		dir_beat[1] = beat_of(MODE_STORE, 8'h00, 32'h0, '0, 8'd5, 8'd1,
			-32'sd65536, 32'sd65536, 4'b0101, 8'd80, 8'd81);
		dir_beat[2] = beat_of(MODE_PROBE, 8'h00, 32'h0, '1, 8'd0, 8'd0, 0, 0, 4'h0, 8'd0, 8'd0);
		dir_beat[3] = beat_of(MODE_STORE, 8'h00, 32'h0, '1, 8'd5, 8'd2,
			32'sd0, 32'sd131072, 4'b1010, 8'd0, 8'd7);
		dir_beat[4] = beat_of(MODE_PROBE, 8'h00, 32'h0, '0, 8'd0, 8'd0, 0, 0, 4'h0, 8'd0, 8'd0);
		dir_beat[5] = beat_of(MODE_STORE, 8'h00, 32'h0, '0, 8'd5, 8'd2,
			32'sd100, 32'sd50, 4'b0000, 8'd1, 8'd1);
		dir_beat[6] = beat_of(MODE_STORE, 8'h00, 32'h0, '0, 8'd1, 8'd2,
			32'sh8000_0000, 32'sh7fff_ffff, 4'h3, 8'd2, 8'd2);
		dir_beat[7] = beat_of(MODE_STORE, 8'h00, 32'h0, '0, 8'd9, 8'd3,
			32'sh8000_0000, 32'sh7fff_ffff, 4'hf, 8'd255, 8'd0);
		dir_beat[8] = beat_of(MODE_STORE, 8'h00, 32'h1, '0, 8'd255, 8'd255, 0, 0, 4'h0, 8'd3, 8'd3);
		dir_beat[9] = beat_of(MODE_STORE, 8'h00, 32'h2, '0, 8'd0, 8'd0, -32'sd1, 1, 4'h1, 8'd4, 8'd4);
		dir_beat[10] = beat_of(MODE_STORE, 8'h00, 32'h3, '0, 8'd0, 8'd3, -32'sd9, 9, 4'h2, 8'd5, 8'd5);
		dir_beat[11] = beat_of(MODE_STORE, 8'h00, 32'h4, '0, 8'd7, 8'd3, 0, 1, 4'h4, 8'd6, 8'd6);
		dir_beat[12] = beat_of(MODE_STORE, 8'h00, 32'h5, '0, 8'd7, 8'd3, 0, 1, 4'h8, 8'd6, 8'd6);
		for (int i = 0; i < 4; i++)
			dir_beat[13 + i - 1] = dir_beat[13 + i - 1];
		dir_beat[13] = beat_of(MODE_PROBE, 8'h00, 32'h5, '0, 8'd0, 8'd0, 0, 0, 4'h0, 8'd0, 8'd0);
		dir_beat[14] = beat_of(MODE_PROBE, 8'h40, 32'h0, '0, 8'd0, 8'd0, 0, 0, 4'h0, 8'd0, 8'd0);
		dir_beat[15] = beat_of(MODE_STORE, 8'hff, 32'hffff_ffff, '1, 8'hff, 8'hff,
			32'sh7fff_ffff, 32'sh8000_0000, 4'hf, 8'hff, 8'hff);
		for (int i = 0; i < NDIR; i++) dir_typed[i] = 1'b0;
		dir_result[0] = miss;
		dir_typed[0] = 1'b1;
		dir_result[1] = st;
		dir_typed[1] = 1'b1;
		dir_result[15] = st;
		dir_typed[15] = 1'b1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_key_mode(1'b0);

		send_idle_pct = 15;
		recv_idle_pct = 75;
		for (int i = 0; i < NDIR; i++) begin
			if (dir_typed[i] && table_peek(dir_beat[i]) !== dir_result[i]) begin
				$display("%0t: row %0d expected %h model %h", $time, i, dir_result[i],
					table_peek(dir_beat[i]));
				errors++;
			end
			send_beat(dir_beat[i]);
		end

		// full-key mode: same tags with a different identity collide
		set_key_mode(1'b1);
		send_beat(beat_of(MODE_PROBE, 8'h00, 32'h0, 64'h1234, 8'd0, 8'd0, 32'sd0, 32'sd0,
			4'h0, 8'd0, 8'd0));
		send_beat(beat_of(MODE_STORE, 8'h00, 32'h0, 64'h1234, 8'd2, 8'd3, 32'sd0, 32'sd5,
			4'h1, 8'd1, 8'd2));
		send_beat(beat_of(MODE_PROBE, 8'h00, 32'h0, 64'h1234, 8'd0, 8'd0, 32'sd0, 32'sd0,
			4'h0, 8'd0, 8'd0));

		// receiver holds off while the sender keeps offering
		fork
			begin
				hold_recv = 1'b1;
				repeat (300) @(posedge clk);
				hold_recv = 1'b0;
			end
			for (int i = 0; i < 12; i++) send_beat(random_beat(4, 6));
		join

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 75;
				recv_idle_pct = 15;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_key_mode(ph[0]);
			for (int i = 0; i < 235; i++) begin
				b = random_beat((ph < 3) ? 4 : 64, (ph < 3) ? 6 : 40);
				send_beat(b);
			end
		end

		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d beats in, %0d out, %0d stores, %0d probe hits, %0d with collisions",
			beats_in, beats_out, store_writes, probe_hits, colls_seen);
		$display("both key modes, idle mixes and a long output hold-off were exercised");
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (out_data.hit) probe_hits++;
			if (out_data.collisions != 0) colls_seen++;
		end
	end

endmodule

>>> sim.f
src/sat_pkg.sv
src/sat_ram.sv
src/set_assoc_transposition_table_unit.sv
test/tb_set_assoc_transposition_table_unit.sv
